@@ rtl/ghalloc_pkg.sv @@
// shared field widths, mode codes and status codes of the generational handle allocator
`default_nettype none

package ghalloc_pkg;

    // field widths of one word on either stream
    localparam int ID_BITS       = 10;
    localparam int VER_BITS      = 16;
    localparam int MODE_BITS     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int COUNT_BITS    = 11;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 56;

    // request kinds carried on the input tuser
    localparam logic [MODE_BITS-1:0] MODE_CREATE  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DESTROY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_FLUSH   = 2'd3;

    // result codes carried on the output tuser
    localparam logic [STATUS_BITS-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_TABLE_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_QUEUE_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_ALIVE   = 2'd3;

endpackage

`default_nettype wire

@@ rtl/generational_handle_allocator.sv @@
// generational handle allocator: version table, free id stack and deferred destroy queue
// create writes version zero for a new id, or pops a reused id and reads its version;
//   destroy and query read the version table, then check; flush walks the queue one entry
//   at a time (queue read, then version table read-modify-write on the shared table port)
// throughput: one word in flight at a time, the next accepted once the result sits in the
//   output register; the output register holds one finished word while the next runs
// reset: rst_n clears the sequencer, id counter, stack and queue depths; memories are not cleared
`default_nettype none

module generational_handle_allocator #(
    parameter int MAX_ENTITIES  = 1024,
    parameter int PENDING_SLOTS = 128,
    parameter int VERSION_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // entity_id[9:0], entity_version[25:10], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [55:0] m_axis_tdata,   // handle_id[9:0], handle_version[25:10],
                                             // alive[26], active_count[37:27],
                                             // free_count[48:38], zero pad
    output logic      [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int ID_W   = $clog2(MAX_ENTITIES);
    localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
    localparam int PD_W   = $clog2(PENDING_SLOTS + 1);
    localparam int PQ_AW  = PENDING_SLOTS > 1 ? $clog2(PENDING_SLOTS) : 1;
    localparam int VB     = ghalloc_pkg::VER_BITS;
    localparam int IB     = ghalloc_pkg::ID_BITS;
    localparam int PQ_W   = VB + ID_W;
    localparam int CMP_W  = VERSION_BITS > VB ? VERSION_BITS : VB;
    localparam int SUM_W  = (CNT_W > PD_W ? CNT_W : PD_W) + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_C_STK = 3'd1;
    localparam logic [2:0] S_C_VT  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_FL_Q  = 3'd4;
    localparam logic [2:0] S_FL_V  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [ghalloc_pkg::MODE_BITS-1:0]   mode_reg, mode_next;
    logic [IB-1:0]                       id_reg, id_next;
    logic [VB-1:0]                       ver_reg, ver_next;
    logic                                alive_reg, alive_next;
    logic [ghalloc_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [CNT_W-1:0]                    nid_reg, nid_next;
    logic [CNT_W-1:0]                    fd_reg, fd_next;
    logic [PD_W-1:0]                     pd_reg, pd_next;
    logic [PD_W-1:0]                     idx_reg, idx_next;
    logic [ID_W-1:0]                     pid_reg, pid_next;
    logic [VB-1:0]                       pver_reg, pver_next;
    logic                                ovalid_reg, ovalid_next;
    logic [55:0]                         odata_reg, odata_next;
    logic [1:0]                          ouser_reg, ouser_next;

    // memory ports
    logic                     vt_we;
    logic [ID_W-1:0]          vt_waddr, vt_raddr;
    logic [VERSION_BITS-1:0]  vt_wdata, vt_rdata;
    logic                     fs_we;
    logic [ID_W-1:0]          fs_waddr, fs_raddr;
    logic [ID_W-1:0]          fs_wdata, fs_rdata;
    logic                     pq_we;
    logic [PQ_AW-1:0]         pq_waddr, pq_raddr;
    logic [PQ_W-1:0]          pq_wdata, pq_rdata;

    // helper views
    logic [31:0]       in_id32, id32, nid32, fs32, pid32;
    logic [CMP_W-1:0]  vt_cmp, ver_cmp, pver_cmp;
    logic              id_known, pid_known;
    logic              ver_match, pver_match;
    logic [PD_W-1:0]   idx_inc;
    logic [SUM_W-1:0]  used_sum, nid_wide, active_wide;
    logic [31:0]       active32, fd32;

    assign in_id32   = 32'(s_axis_tdata[IB-1:0]);
    assign id32      = 32'(id_reg);
    assign nid32     = 32'(nid_reg);
    assign fs32      = 32'(fs_rdata);
    assign pid32     = 32'(pid_reg);
    assign vt_cmp    = CMP_W'(vt_rdata);
    assign ver_cmp   = CMP_W'(ver_reg);
    assign pver_cmp  = CMP_W'(pver_reg);
    assign id_known  = id32 < nid32;
    assign pid_known = pid32 < nid32;
    assign ver_match  = vt_cmp == ver_cmp;
    assign pver_match = vt_cmp == pver_cmp;
    assign idx_inc   = idx_reg + 1'b1;

    // active count after the step, saturated at zero
    assign used_sum    = SUM_W'(fd_reg) + SUM_W'(pd_reg);
    assign nid_wide    = SUM_W'(nid_reg);
    assign active_wide = (nid_wide > used_sum) ? (nid_wide - used_sum) : '0;
    assign active32    = 32'(active_wide);
    assign fd32        = 32'(fd_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        id_next     = id_reg;
        ver_next    = ver_reg;
        alive_next  = alive_reg;
        status_next = status_reg;
        nid_next    = nid_reg;
        fd_next     = fd_reg;
        pd_next     = pd_reg;
        idx_next    = idx_reg;
        pid_next    = pid_reg;
        pver_next   = pver_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;

        vt_we    = 1'b0;
        vt_waddr = '0;
        vt_wdata = '0;
        vt_raddr = '0;
        fs_we    = 1'b0;
        fs_waddr = '0;
        fs_wdata = '0;
        fs_raddr = '0;
        pq_we    = 1'b0;
        pq_waddr = '0;
        pq_wdata = '0;
        pq_raddr = '0;

        // output word taken
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next   = s_axis_tuser;
                    id_next     = s_axis_tdata[IB-1:0];
                    ver_next    = s_axis_tdata[IB+VB-1:IB];
                    alive_next  = 1'b0;
                    status_next = ghalloc_pkg::STATUS_OK;
                    case (s_axis_tuser)
                        ghalloc_pkg::MODE_CREATE:
                        begin
                            if (fd_reg != '0)
                            begin
                                // pop the most recently freed id
                                fd_next   = fd_reg - 1'b1;
                                fs_raddr  = fd_next[ID_W-1:0];
                                state_next = S_C_STK;
                            end
                            else if (nid_reg < CNT_W'(MAX_ENTITIES))
                            begin
                                // fresh id at version zero
                                vt_we      = 1'b1;
                                vt_waddr   = nid_reg[ID_W-1:0];
                                vt_wdata   = '0;
                                id_next    = nid32[IB-1:0];
                                ver_next   = '0;
                                nid_next   = nid_reg + 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                status_next = ghalloc_pkg::STATUS_TABLE_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        ghalloc_pkg::MODE_DESTROY,
                        ghalloc_pkg::MODE_QUERY:
                        begin
                            vt_raddr   = in_id32[ID_W-1:0];
                            state_next = S_CHK;
                        end
                        ghalloc_pkg::MODE_FLUSH:
                        begin
                            idx_next = '0;
                            pq_raddr = '0;
                            if (pd_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FL_Q;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_C_STK:
            begin
                // stack word ready, fetch its stored version
                vt_raddr   = fs_rdata;
                id_next    = fs32[IB-1:0];
                state_next = S_C_VT;
            end

            S_C_VT:
            begin
                ver_next   = vt_cmp[VB-1:0];
                state_next = S_DONE;
            end

            S_CHK:
            begin
                if (mode_reg == ghalloc_pkg::MODE_DESTROY)
                begin
                    if (!(id_known && ver_match))
                    begin
                        status_next = ghalloc_pkg::STATUS_NOT_ALIVE;
                    end
                    else
                    begin
                        alive_next = 1'b1;
                        if (pd_reg >= PD_W'(PENDING_SLOTS))
                        begin
                            status_next = ghalloc_pkg::STATUS_QUEUE_FULL;
                        end
                        else
                        begin
                            // queue the handle for the next flush
                            pq_we    = 1'b1;
                            pq_waddr = pd_reg[PQ_AW-1:0];
                            pq_wdata = {ver_reg, id32[ID_W-1:0]};
                            pd_next  = pd_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    alive_next = id_known && ver_match;
                end
                state_next = S_DONE;
            end

            S_FL_Q:
            begin
                // queue entry ready, fetch the current version of its id
                pid_next   = pq_rdata[ID_W-1:0];
                pver_next  = pq_rdata[PQ_W-1:ID_W];
                vt_raddr   = pq_rdata[ID_W-1:0];
                state_next = S_FL_V;
            end

            S_FL_V:
            begin
                // bump a still-live entry and recycle its id
                if (pid_known && pver_match)
                begin
                    vt_we    = 1'b1;
                    vt_waddr = pid_reg;
                    vt_wdata = vt_rdata + 1'b1;
                    if (fd_reg < CNT_W'(MAX_ENTITIES))
                    begin
                        fs_we    = 1'b1;
                        fs_waddr = fd_reg[ID_W-1:0];
                        fs_wdata = pid_reg;
                        fd_next  = fd_reg + 1'b1;
                    end
                end
                idx_next = idx_inc;
                pq_raddr = idx_inc[PQ_AW-1:0];
                if (idx_inc == pd_reg)
                begin
                    pd_next    = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FL_Q;
                end
            end

            S_DONE:
            begin
                // load the result once the output register is free
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {7'd0,
                                   fd32[ghalloc_pkg::COUNT_BITS-1:0],
                                   active32[ghalloc_pkg::COUNT_BITS-1:0],
                                   alive_reg,
                                   ver_reg,
                                   id_reg};
                    ouser_next  = status_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nid_reg    <= '0;
            fd_reg     <= '0;
            pd_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nid_reg    <= nid_next;
            fd_reg     <= fd_next;
            pd_reg     <= pd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        id_reg     <= id_next;
        ver_reg    <= ver_next;
        alive_reg  <= alive_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        pid_reg    <= pid_next;
        pver_reg   <= pver_next;
        odata_reg  <= odata_next;
        ouser_reg  <= ouser_next;
    end

    // version table
    ghalloc_ram #(
        .WIDTH (VERSION_BITS),
        .DEPTH (MAX_ENTITIES)
    ) u_version_ram (
        .clk   (clk),
        .we    (vt_we),
        .waddr (vt_waddr),
        .wdata (vt_wdata),
        .raddr (vt_raddr),
        .rdata (vt_rdata)
    );

    // free id stack
    ghalloc_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_ENTITIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    // deferred destroy queue
    ghalloc_ram #(
        .WIDTH (PQ_W),
        .DEPTH (PENDING_SLOTS)
    ) u_pending_ram (
        .clk   (clk),
        .we    (pq_we),
        .waddr (pq_waddr),
        .wdata (pq_wdata),
        .raddr (pq_raddr),
        .rdata (pq_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/ghalloc_ram.sv @@
// generic single write port, single read port ram with registered read data
`default_nettype none

module ghalloc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_generational_handle_allocator.sv @@
// self-checking stream testbench for the generational handle allocator

// one expected output word, unpacked into its fields
typedef struct packed {
    logic [ghalloc_pkg::ID_BITS-1:0]     id;
    logic [ghalloc_pkg::VER_BITS-1:0]    ver;
    logic                                alive;
    logic [ghalloc_pkg::STATUS_BITS-1:0] status;
    logic [ghalloc_pkg::COUNT_BITS-1:0]  active;
    logic [ghalloc_pkg::COUNT_BITS-1:0]  free_cnt;
} alloc_result_t;

// shadow copy of the allocator state plus the words still awaited from the block
class handle_allocator_shadow #(int SLOTS = 1024, int QUEUE_SLOTS = 128);
    localparam int ID_W   = ghalloc_pkg::ID_BITS;
    localparam int VER_W  = ghalloc_pkg::VER_BITS;
    localparam int CNT_W  = ghalloc_pkg::COUNT_BITS;
    localparam int ST_W   = ghalloc_pkg::STATUS_BITS;
    localparam int MODE_W = ghalloc_pkg::MODE_BITS;
    localparam int OUT_W  = ghalloc_pkg::OUT_DATA_BITS;

    logic [VER_W-1:0]    version_of [SLOTS];
    logic [ID_W-1:0]     free_ids [SLOTS];
    logic [ID_W-1:0]     queued_id [QUEUE_SLOTS];
    logic [VER_W-1:0]    queued_ver [QUEUE_SLOTS];
    int unsigned         next_id;
    int unsigned         free_depth;
    int unsigned         queue_depth;
    int unsigned         peak_free;
    alloc_result_t       awaited [$];
    int unsigned         errors;
    int unsigned         results_seen;
    int unsigned         mode_seen [4];
    int unsigned         status_seen [4];

    function new();
        next_id      = 0;
        free_depth   = 0;
        queue_depth  = 0;
        peak_free    = 0;
        errors       = 0;
        results_seen = 0;
        foreach (mode_seen[i]) mode_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // a handle is live when its slot was handed out and the version still matches
    function bit is_live(logic [ID_W-1:0] id, logic [VER_W-1:0] ver);
        if (id >= next_id)
            return 1'b0;
        return version_of[id] == ver;
    endfunction

    // advance the shadow state by one accepted word and queue the expected result
    function void note_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                               logic [VER_W-1:0] ver);
        alloc_result_t r;
        int unsigned   used;
        r.id     = id;
        r.ver    = ver;
        r.alive  = 1'b0;
        r.status = ghalloc_pkg::STATUS_OK;
        mode_seen[mode]++;
        case (mode)
            ghalloc_pkg::MODE_CREATE:
                if (free_depth > 0)
                begin
                    // reuse the most recently freed id
                    free_depth--;
                    r.id  = free_ids[free_depth];
                    r.ver = version_of[r.id];
                end
                else if (next_id < SLOTS)
                begin
                    r.id  = ID_W'(next_id);
                    r.ver = '0;
                    version_of[next_id] = '0;
                    next_id++;
                end
                else
                    r.status = ghalloc_pkg::STATUS_TABLE_FULL;
            ghalloc_pkg::MODE_DESTROY:
                if (!is_live(id, ver))
                    r.status = ghalloc_pkg::STATUS_NOT_ALIVE;
                else
                begin
                    r.alive = 1'b1;
                    if (queue_depth >= QUEUE_SLOTS)
                        r.status = ghalloc_pkg::STATUS_QUEUE_FULL;
                    else
                    begin
                        queued_id[queue_depth]  = id;
                        queued_ver[queue_depth] = ver;
                        queue_depth++;
                    end
                end
            ghalloc_pkg::MODE_QUERY:
                r.alive = is_live(id, ver);
            ghalloc_pkg::MODE_FLUSH:
            begin
                // walk the deferred destroys in order, skipping stale duplicates
                for (int i = 0; i < queue_depth; i++)
                    if (is_live(queued_id[i], queued_ver[i]))
                    begin
                        version_of[queued_id[i]] = version_of[queued_id[i]] + 1'b1;
                        if (free_depth < SLOTS)
                        begin
                            free_ids[free_depth] = queued_id[i];
                            free_depth++;
                        end
                    end
                queue_depth = 0;
            end
        endcase
        // counts after the step, active saturating at zero
        used       = free_depth + queue_depth;
        r.active   = CNT_W'((next_id > used) ? next_id - used : 0);
        r.free_cnt = CNT_W'(free_depth);
        if (free_depth > peak_free)
            peak_free = free_depth;
        status_seen[r.status]++;
        awaited.insert(awaited.size(), r);
    endfunction

    function void compare_field(string name, longint stamp, logic [15:0] want,
                                logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 20)
                $display("%0d ns: %s mismatch on word %0d: expected %0d, actual %0d",
                         stamp, name, results_seen, want, got);
        end
    endfunction

    // compare one accepted output word with the oldest expectation
    function void check_result(logic [OUT_W-1:0] data,
                               logic [ST_W-1:0] user, longint stamp);
        alloc_result_t want;
        results_seen++;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 20)
                $display("%0d ns: unexpected word: expected none, actual data %h status %0d",
                         stamp, data, user);
            return;
        end
        want = awaited.pop_front();
        compare_field("handle_id", stamp, 16'(want.id), 16'(data[9:0]));
        compare_field("handle_version", stamp, want.ver, data[25:10]);
        compare_field("alive", stamp, 16'(want.alive), 16'(data[26]));
        compare_field("status", stamp, 16'(want.status), 16'(user));
        compare_field("active_count", stamp, 16'(want.active), 16'(data[37:27]));
        compare_field("free_count", stamp, 16'(want.free_cnt), 16'(data[48:38]));
    endfunction
endclass

module tb_generational_handle_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENT     = 1024;
    localparam int PEND_SLOTS  = 128;
    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 4000;
    localparam int ID_W        = ghalloc_pkg::ID_BITS;
    localparam int VER_W       = ghalloc_pkg::VER_BITS;
    localparam int MODE_W      = ghalloc_pkg::MODE_BITS;
    localparam int ST_W        = ghalloc_pkg::STATUS_BITS;
    localparam int IN_W        = ghalloc_pkg::IN_DATA_BITS;
    localparam int OUT_W       = ghalloc_pkg::OUT_DATA_BITS;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_W-1:0]          s_axis_tdata = '0;
    logic [MODE_W-1:0]        s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         m_axis_tdata;
    logic [ST_W-1:0]          m_axis_tuser;

    handle_allocator_shadow #(.SLOTS(MAX_ENT), .QUEUE_SLOTS(PEND_SLOTS)) shadow;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    generational_handle_allocator #(
        .MAX_ENTITIES  (MAX_ENT),
        .PENDING_SLOTS (PEND_SLOTS),
        .VERSION_BITS  (VER_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // idle lengths: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one word, wait for the handshake, then maybe idle
    task automatic issue(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                         logic [VER_W-1:0] ver);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_W - ID_W - VER_W){1'b0}}, ver, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        shadow.note_request(mode, id, ver);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            burst_left = 30;
            gap = 0;
        end
        else
            gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pause until every expected word has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
    endtask

    // hand-picked words from a fresh reset
    task automatic run_directed();
        issue(ghalloc_pkg::MODE_CREATE, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_CREATE, 10'h3FF, 16'hFFFF);
        issue(ghalloc_pkg::MODE_CREATE, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_QUERY, 10'd1, 16'd0);
        issue(ghalloc_pkg::MODE_QUERY, 10'd1, 16'd1);
        issue(ghalloc_pkg::MODE_QUERY, 10'h3FF, 16'hFFFF);
        // destroys of slots never handed out or with the wrong version are ignored
        issue(ghalloc_pkg::MODE_DESTROY, 10'd5, 16'd0);
        issue(ghalloc_pkg::MODE_DESTROY, 10'd2, 16'd7);
        // same handles queued twice, so the active count saturates at zero
        issue(ghalloc_pkg::MODE_DESTROY, 10'd1, 16'd0);
        issue(ghalloc_pkg::MODE_DESTROY, 10'd1, 16'd0);
        issue(ghalloc_pkg::MODE_DESTROY, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_DESTROY, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_QUERY, 10'd1, 16'd0);
        issue(ghalloc_pkg::MODE_FLUSH, 10'h3FF, 16'hFFFF);
        issue(ghalloc_pkg::MODE_QUERY, 10'd1, 16'd0);
        issue(ghalloc_pkg::MODE_QUERY, 10'd1, 16'd1);
        // freed ids come back last in, first out with the bumped version
        issue(ghalloc_pkg::MODE_CREATE, 10'h2AA, 16'h5555);
        issue(ghalloc_pkg::MODE_CREATE, 10'h155, 16'hAAAA);
        issue(ghalloc_pkg::MODE_CREATE, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_FLUSH, 10'd0, 16'd0);
        issue(ghalloc_pkg::MODE_DESTROY, 10'd3, 16'd0);
        issue(ghalloc_pkg::MODE_QUERY, 10'd3, 16'd0);
        issue(ghalloc_pkg::MODE_FLUSH, 10'h200, 16'h8000);
    endtask

    // mostly well-formed traffic against live handles, with stale and random noise
    task automatic run_random(int unsigned count);
        logic [MODE_W-1:0]    mode;
        logic [ID_W-1:0]      id;
        logic [VER_W-1:0]     ver;
        int unsigned          pick;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k == count / 2)
                wait_for_results();
            pick = $urandom_range(0, 99);
            id   = ID_W'($urandom);
            ver  = VER_W'($urandom);
            if (pick < 30)
                mode = ghalloc_pkg::MODE_CREATE;
            else if (pick < 62)
                mode = ghalloc_pkg::MODE_DESTROY;
            else if (pick < 90)
                mode = ghalloc_pkg::MODE_QUERY;
            else
                mode = ghalloc_pkg::MODE_FLUSH;
            if ((mode == ghalloc_pkg::MODE_DESTROY || mode == ghalloc_pkg::MODE_QUERY)
                && shadow.next_id > 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    id = ID_W'($urandom_range(0, shadow.next_id - 1));
                if (pick < 70)
                    ver = shadow.version_of[id];
                else if (pick < 78)
                    ver = shadow.version_of[id] - 1'b1;
                else if (pick < 85)
                    ver = shadow.version_of[id] + 1'b1;
            end
            issue(mode, id, ver);
        end
    endtask

    // one handle queued over and over until the queue overflows, then flushed
    task automatic run_queue_overflow();
        logic [ID_W-1:0]  id;
        logic [VER_W-1:0] ver;
        issue(ghalloc_pkg::MODE_FLUSH, ID_W'($urandom), VER_W'($urandom));
        if (shadow.free_depth > 0)
            id = shadow.free_ids[shadow.free_depth - 1];
        else
            id = ID_W'(shadow.next_id);
        issue(ghalloc_pkg::MODE_CREATE, ID_W'($urandom), VER_W'($urandom));
        ver = shadow.version_of[id];
        while (shadow.queue_depth < PEND_SLOTS)
            issue(ghalloc_pkg::MODE_DESTROY, id, ver);
        // queue full: live destroys are dropped
        issue(ghalloc_pkg::MODE_DESTROY, id, ver);
        issue(ghalloc_pkg::MODE_DESTROY, id, ver);
        issue(ghalloc_pkg::MODE_QUERY, id, ver);
        // first copy bumps the version, every later copy is stale
        issue(ghalloc_pkg::MODE_FLUSH, ID_W'($urandom), VER_W'($urandom));
        issue(ghalloc_pkg::MODE_QUERY, id, ver);
        issue(ghalloc_pkg::MODE_CREATE, ID_W'($urandom), VER_W'($urandom));
    endtask

    // output side: random back-pressure plus one long hold-off
    initial
    begin : result_sink
        int unsigned hold;
        bit          held_long;
        hold      = 0;
        held_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_long && shadow.results_seen >= 150)
            begin
                held_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 39) == 0)
            begin
                m_axis_tready <= 1'b1;
                hold = 120;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold = gap_len();
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    // check each accepted output word
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_result(m_axis_tdata, m_axis_tuser, $time);

    // watchdog on cycles where no word moves on either side
    always @(posedge clk)
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0d ns: watchdog: no word moved for %0d cycles, %0d words awaited",
                         $time, quiet_cycles, shadow.awaited.size());
                $display("tb_generational_handle_allocator: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end

    // reset, stimulus phases and the verdict
    initial
    begin : stimulus
        shadow = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_for_results();
        run_random(450);
        run_queue_overflow();
        wait_for_results();
        run_random(140);
        wait_for_results();
        repeat (300) @(posedge clk);
        $display("covered %0d words: %0d create, %0d destroy, %0d query, %0d flush",
                 shadow.results_seen, shadow.mode_seen[ghalloc_pkg::MODE_CREATE],
                 shadow.mode_seen[ghalloc_pkg::MODE_DESTROY],
                 shadow.mode_seen[ghalloc_pkg::MODE_QUERY],
                 shadow.mode_seen[ghalloc_pkg::MODE_FLUSH]);
        $display("statuses: %0d ok, %0d table full, %0d queue full, %0d dead; free stack peak %0d",
                 shadow.status_seen[ghalloc_pkg::STATUS_OK],
                 shadow.status_seen[ghalloc_pkg::STATUS_TABLE_FULL],
                 shadow.status_seen[ghalloc_pkg::STATUS_QUEUE_FULL],
                 shadow.status_seen[ghalloc_pkg::STATUS_NOT_ALIVE],
                 shadow.peak_free);
        if (shadow.errors == 0 && shadow.awaited.size() == 0)
            $display("tb_generational_handle_allocator: PASS");
        else
            $display("tb_generational_handle_allocator: FAIL");
        $finish;
    end

endmodule
